/* rtl/shifting_blitter_video_memory_assert.svh */
// Assertion macros shared by the blitter RTL.
`ifndef SHIFTING_BLITTER_VIDEO_MEMORY_ASSERT_SVH
`define SHIFTING_BLITTER_VIDEO_MEMORY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SBVM_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBVM_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

/* rtl/sbvm_pkg.sv */
// Shared types, codes and helpers for the shifting blitter.
`timescale 1ns / 1ps
package sbvm_pkg;

    localparam int ADDR_W    = 13;
    localparam int CFG_IDX_W = 2;

    // Bus commands
    localparam logic [1:0] CMD_VRD = 2'd0;
    localparam logic [1:0] CMD_VWR = 2'd1;
    localparam logic [1:0] CMD_CRD = 2'd2;
    localparam logic [1:0] CMD_CWR = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd1;

    // Logic unit functions, selected by the complement of mode bits 3..0
    localparam logic [3:0] LF_NOT_S    = 4'd0;
    localparam logic [3:0] LF_NOR      = 4'd1;
    localparam logic [3:0] LF_NS_AND_D = 4'd2;
    localparam logic [3:0] LF_ZERO     = 4'd3;
    localparam logic [3:0] LF_NAND     = 4'd4;
    localparam logic [3:0] LF_NOT_D    = 4'd5;
    localparam logic [3:0] LF_XOR      = 4'd6;
    localparam logic [3:0] LF_S_AND_ND = 4'd7;
    localparam logic [3:0] LF_NS_OR_D  = 4'd8;
    localparam logic [3:0] LF_XNOR     = 4'd9;
    localparam logic [3:0] LF_DEST     = 4'd10;
    localparam logic [3:0] LF_AND      = 4'd11;
    localparam logic [3:0] LF_ONE      = 4'd12;
    localparam logic [3:0] LF_S_OR_ND  = 4'd13;
    localparam logic [3:0] LF_OR       = 4'd14;
    localparam logic [3:0] LF_SRC      = 4'd15;

    localparam logic [15:0]       MASK_BASE = 16'hff00;
    localparam logic [ADDR_W-1:0] COL_STEP  = 13'h100;

    typedef struct packed {
        logic [7:0] read_data;
        logic       pal_we;
        logic [5:0] pal_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_result;

    typedef struct packed {
        logic              pix_we;
        logic [7:0]        pix1;
        logic [7:0]        pix2;
        logic              col_we1;
        logic              col_we2;
        logic [ADDR_W-1:0] col_addr1;
        logic [ADDR_W-1:0] col_addr2;
        logic [7:0]        col_data1;
        logic [7:0]        col_data2;
        logic              latch_we;
        logic [4:0]        latch_val;
        t_result           res;
    } t_alu_out;

    // Reverse bit order of a byte
    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    // Stretch a 3-bit level to 8 bits
    function automatic logic [7:0] expand3(input logic [2:0] v);
        return {v, v, v[2:1]};
    endfunction

endpackage

/* rtl/sbvm_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module sbvm_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 13
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/sbvm_alu.sv */
// Shift, mask and logic unit: computes memory updates and the result of one access.
`timescale 1ns / 1ps
module sbvm_alu (
    input  logic [1:0]                  i_cmd,
    input  logic [13:0]                 i_addr,
    input  logic [7:0]                  i_data,
    input  logic [7:0]                  i_shift_ctl,
    input  logic [7:0]                  i_mode_ctl,
    input  logic [4:0]                  i_latch,
    input  logic [7:0]                  i_pix1,
    input  logic [7:0]                  i_pix2,
    input  logic [7:0]                  i_col1,
    output sbvm_pkg::t_alu_out          o_out
);
    import sbvm_pkg::*;

    logic [2:0]        sh;
    logic              mirror;
    logic [ADDR_W-1:0] a1;
    logic [ADDR_W-1:0] a2;
    logic [7:0]        dm;
    logic [15:0]       ds;
    logic [15:0]       mask;
    logic [15:0]       d0;
    logic [15:0]       keep;
    logic [15:0]       res;
    logic [7:0]        gath;
    logic [15:0]       rot;
    logic              prot;
    logic [2:0]        lvl_r;

    always_comb begin
        // Shift set chosen by address bit 13
        sh     = i_addr[13] ? i_shift_ctl[3:1] : i_shift_ctl[7:5];
        mirror = i_addr[13] ? i_shift_ctl[0] : i_shift_ctl[4];
        a1     = i_addr[ADDR_W-1:0];
        a2     = a1 + COL_STEP;

        // Column mask, trimmed on the roll column
        mask = MASK_BASE >> sh;
        if (i_addr[12:8] == 5'h1f) begin
            mask = i_mode_ctl[4] ? (mask & 16'h00ff) : (mask & 16'hff00);
        end

        dm   = mirror ? flip8(i_data) : i_data;
        ds   = ({dm, 8'h00} >> sh) & mask;
        d0   = {i_pix1, i_pix2};
        keep = d0 & ~mask;
        d0   = d0 & mask;
        prot = (i_addr[7:5] == 3'd0) && !i_mode_ctl[5];

        // Logic unit
        case (~i_mode_ctl[3:0])
            LF_NOT_S:    res = ds ^ mask;
            LF_NOR:      res = (ds | d0) ^ mask;
            LF_NS_AND_D: res = (ds ^ mask) & d0;
            LF_ZERO:     res = 16'h0000;
            LF_NAND:     res = (ds & d0) ^ mask;
            LF_NOT_D:    res = d0 ^ mask;
            LF_XOR:      res = ds ^ d0;
            LF_S_AND_ND: res = ds & (d0 ^ mask);
            LF_NS_OR_D:  res = (ds ^ mask) | d0;
            LF_XNOR:     res = ds ^ d0 ^ mask;
            LF_DEST:     res = d0;
            LF_AND:      res = ds & d0;
            LF_ONE:      res = mask;
            LF_S_OR_ND:  res = ds | (d0 ^ mask);
            LF_OR:       res = ds | d0;
            default:     res = ds;
        endcase
        res = keep | res;

        // Gather and rotate back for reads
        gath = (i_pix1 & mask[15:8]) | (i_pix2 & mask[7:0]);
        rot  = {gath, gath} << sh;

        lvl_r = {i_data[1:0], a1[8]};

        o_out = '0;
        case (i_cmd)
            CMD_VRD: begin
                o_out.res.read_data = rot[15:8];
            end
            CMD_VWR: begin
                if (!prot) begin
                    o_out.pix_we    = 1'b1;
                    o_out.pix1      = res[15:8];
                    o_out.pix2      = res[7:0];
                    o_out.col_addr1 = a1;
                    o_out.col_addr2 = a2;
                    o_out.col_data1 = {3'b000, i_latch};
                    o_out.col_data2 = {3'b000, i_latch};
                    if (!i_addr[13] && !i_mode_ctl[7]) begin
                        o_out.col_we1 = |mask[15:8];
                        o_out.col_we2 = |mask[7:0];
                    end
                end
            end
            CMD_CRD: begin
                o_out.res.read_data = i_col1;
            end
            CMD_CWR: begin
                o_out.latch_we  = 1'b1;
                o_out.latch_val = i_data[4:0];
                o_out.col_we1   = 1'b1;
                if (a1[7:5] == 3'd0) begin
                    // Palette region: store at both halves of bit 8
                    o_out.col_we2   = 1'b1;
                    o_out.col_addr1 = {a1[12:9], 1'b0, a1[7:0]};
                    o_out.col_addr2 = {a1[12:9], 1'b1, a1[7:0]};
                    o_out.col_data1 = i_data;
                    o_out.col_data2 = i_data;
                    if (i_mode_ctl[6]) begin
                        o_out.res.pal_we    = 1'b1;
                        o_out.res.pal_index = {a1[9], a1[4:0]};
                        o_out.res.red       = expand3(lvl_r);
                        o_out.res.green     = expand3(i_data[7:5]);
                        o_out.res.blue      = expand3(i_data[4:2]);
                    end
                end else begin
                    o_out.col_addr1 = a1;
                    o_out.col_data1 = i_mode_ctl[7] ? {3'b000, i_latch}
                                                    : {3'b000, i_data[4:0]};
                end
            end
            default: begin
                o_out = '0;
            end
        endcase
    end

endmodule

/* rtl/shifting_blitter_video_memory.sv */
// Shifting blitter top level: sequencer, configuration registers and memories.
// An accepted item steps through states RD2, EXEC, WR2 and OUT before its result
// shows on the master side. No new item is taken until the sequencer is back in
// IDLE, set by the read-read-modify-write-write sequence on the single read and
// single write port of each memory. Reset: synchronous, active low; then a pass
// clears both memories, no item accepted (configuration writes taken throughout).
`timescale 1ns / 1ps
`include "shifting_blitter_video_memory_assert.svh"
module shifting_blitter_video_memory (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sbvm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    // Access stream; tdata: command[1:0], address[15:2], write_data[23:16]
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,
    // Result stream; tdata: read_data[7:0], pal_index[13:8], red[21:14],
    // green[29:22], blue[37:30], zero pad[39:38]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [39:0]                      m_axis_tdata,
    // tuser: palette_write[0]
    output logic [0:0]                       m_axis_tuser
);
    import sbvm_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD2   = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_WR2   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic [7:0]        r_shift_ctl;
    logic [7:0]        r_mode_ctl;
    logic [4:0]        r_latch;
    logic [1:0]        r_cmd;
    logic [13:0]       r_addr;
    logic [7:0]        r_data;
    logic [7:0]        r_p1;
    logic [7:0]        r_c1;
    logic              r_pix_we2;
    logic [7:0]        r_pix2;
    logic              r_col_we2;
    logic [ADDR_W-1:0] r_col_addr2;
    logic [7:0]        r_col2;
    t_result           r_res;
    logic              r_out_valid;
    t_result           r_out;

    logic              in_xfer;
    logic              out_free;
    logic [ADDR_W-1:0] a2;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        pix_rdata;
    logic [7:0]        col_rdata;
    logic              pix_we;
    logic [ADDR_W-1:0] pix_waddr;
    logic [7:0]        pix_wdata;
    logic              col_we;
    logic [ADDR_W-1:0] col_waddr;
    logic [7:0]        col_wdata;
    t_alu_out          alu;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign a2            = r_addr[ADDR_W-1:0] + COL_STEP;

    // First column from the bus while idle, second column afterwards
    assign rd_addr = (r_state == S_IDLE) ? s_axis_tdata[ADDR_W+1:2] : a2;

    sbvm_alu u_alu (
        .i_cmd       (r_cmd),
        .i_addr      (r_addr),
        .i_data      (r_data),
        .i_shift_ctl (r_shift_ctl),
        .i_mode_ctl  (r_mode_ctl),
        .i_latch     (r_latch),
        .i_pix1      (r_p1),
        .i_pix2      (pix_rdata),
        .i_col1      (r_c1),
        .o_out       (alu)
    );

    // Write port steering: clear sweep, first write, second write
    always_comb begin
        pix_we    = 1'b0;
        pix_waddr = r_addr[ADDR_W-1:0];
        pix_wdata = alu.pix1;
        col_we    = 1'b0;
        col_waddr = alu.col_addr1;
        col_wdata = alu.col_data1;
        case (r_state)
            S_CLEAR: begin
                pix_we    = 1'b1;
                pix_waddr = r_clr_cnt;
                pix_wdata = 8'h00;
                col_we    = 1'b1;
                col_waddr = r_clr_cnt;
                col_wdata = 8'h00;
            end
            S_EXEC: begin
                pix_we = alu.pix_we;
                col_we = alu.col_we1;
            end
            S_WR2: begin
                pix_we    = r_pix_we2;
                pix_waddr = a2;
                pix_wdata = r_pix2;
                col_we    = r_col_we2;
                col_waddr = r_col_addr2;
                col_wdata = r_col2;
            end
            default: begin
                pix_we = 1'b0;
                col_we = 1'b0;
            end
        endcase
    end

    sbvm_ram #(.DATA_W(8), .ADDR_W(ADDR_W)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_raddr (rd_addr),
        .o_rdata (pix_rdata)
    );

    sbvm_ram #(.DATA_W(8), .ADDR_W(ADDR_W)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_raddr (rd_addr),
        .o_rdata (col_rdata)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_cnt == {ADDR_W{1'b1}}) n_state = S_IDLE;
            S_IDLE:  if (in_xfer) n_state = S_RD2;
            S_RD2:   n_state = S_EXEC;
            S_EXEC:  n_state = S_WR2;
            S_WR2:   n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_shift_ctl <= 8'h00;
            r_mode_ctl  <= 8'h00;
            r_latch     <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_SHIFT) begin
                    r_shift_ctl <= i_cfg_data;
                end else if (i_cfg_index == REG_MODE) begin
                    r_mode_ctl <= i_cfg_data;
                end
            end
            if (r_state == S_EXEC && alu.latch_we) begin
                r_latch <= alu.latch_val;
            end
            // Hold the result until the master side takes it
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= s_axis_tdata[1:0];
            r_addr <= s_axis_tdata[15:2];
            r_data <= s_axis_tdata[23:16];
        end
        if (r_state == S_RD2) begin
            r_p1 <= pix_rdata;
            r_c1 <= col_rdata;
        end
        if (r_state == S_EXEC) begin
            r_pix_we2   <= alu.pix_we;
            r_pix2      <= alu.pix2;
            r_col_we2   <= alu.col_we2;
            r_col_addr2 <= alu.col_addr2;
            r_col2      <= alu.col_data2;
            r_res       <= alu.res;
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {2'b00, r_out.blue, r_out.green, r_out.red,
                              r_out.pal_index, r_out.read_data};
    assign m_axis_tuser[0] = r_out.pal_we;

    `SBVM_ASSERT_NOW(a_no_accept_in_clear, r_state == S_CLEAR, !s_axis_tready,
        "item accepted during clearing pass")
    `SBVM_ASSERT_NEXT(a_accept_starts_read, in_xfer, r_state == S_RD2,
        "accepted item did not start its read sequence")
    `SBVM_ASSERT_NOW(a_pix_write_only_video, r_state == S_EXEC && alu.pix_we,
        r_cmd == CMD_VWR, "pixel memory written by a non video-write access")
    `SBVM_ASSERT_NOW(a_palette_fields_zero, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata[39:8] == 32'h0, "palette fields set without palette write")
    `SBVM_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "pending result dropped or changed")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the shifting blitter: bus accesses against a bit-exact shadow.
`timescale 1ns / 1ps
module testbench;
    import sbvm_pkg::*;

    // Indexes past the two registers; the block must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // Mode register bits
    localparam int MODE_ROLL_BIT        = 4;
    localparam int MODE_PROTECT_OFF_BIT = 5;
    localparam int MODE_PAL_EN_BIT      = 6;
    localparam int MODE_COPY_BIT        = 7;

    localparam int PHASES       = 18;
    localparam int PHASE_ITEMS  = 105;
    localparam int HOLD_CYCLES  = 300;

    // Shadow of both memories, the color latch and the registers; queues the
    // result that each accepted access should produce.
    class blit_shadow;
        logic [7:0] pix_mem [8192];
        logic [7:0] col_mem [8192];
        logic [4:0] latch;
        logic [7:0] shift_reg;
        logic [7:0] mode_reg;
        t_result    expected_q [$];
        int         error_count;
        int         result_count;

        function new();
            foreach (pix_mem[i]) begin
                pix_mem[i] = 8'h00;
                col_mem[i] = 8'h00;
            end
            latch        = 5'd0;
            shift_reg    = 8'h00;
            mode_reg     = 8'h00;
            error_count  = 0;
            result_count = 0;
        endfunction

        task report_mismatch(input string what);
            $display("MISMATCH at result %0d: %s", result_count, what);
            error_count++;
        endtask

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
            case (idx)
                REG_SHIFT: shift_reg = value;
                REG_MODE:  mode_reg  = value;
                default: ;
            endcase
        endfunction

        // Window over the two columns, trimmed in the roll column
        function logic [15:0] lane_mask(input logic [13:0] addr, input logic [2:0] sh);
            logic [15:0] mask;
            mask = MASK_BASE >> sh;
            if (addr[12:8] == 5'h1f)
                mask &= mode_reg[MODE_ROLL_BIT] ? 16'h00ff : 16'hff00;
            return mask;
        endfunction

        function logic [7:0] gather_video(input logic [13:0] addr);
            logic [12:0] a1;
            logic [12:0] a2;
            logic [2:0]  sh;
            logic [15:0] mask;
            logic [7:0]  d0;
            logic [15:0] rot;
            a1   = addr[12:0];
            a2   = a1 + COL_STEP;
            sh   = addr[13] ? shift_reg[3:1] : shift_reg[7:5];
            mask = lane_mask(addr, sh);
            d0   = (pix_mem[a1] & mask[15:8]) | (pix_mem[a2] & mask[7:0]);
            // Rotate left by the shift amount
            rot  = {d0, d0} << sh;
            return rot[15:8];
        endfunction

        function void blit_video(input logic [13:0] addr, input logic [7:0] wdata);
            logic [12:0] a1;
            logic [12:0] a2;
            logic [2:0]  sh;
            logic        mirror;
            logic [7:0]  dm;
            logic [15:0] ds;
            logic [15:0] mask;
            logic [15:0] d0;
            logic [15:0] keep;
            logic [15:0] res;
            a1     = addr[12:0];
            a2     = a1 + COL_STEP;
            sh     = addr[13] ? shift_reg[3:1] : shift_reg[7:5];
            mirror = addr[13] ? shift_reg[0] : shift_reg[4];
            // Protected rows are left alone unless protect is off
            if (addr[7:5] == 3'b000 && !mode_reg[MODE_PROTECT_OFF_BIT])
                return;
            for (int i = 0; i < 8; i++)
                dm[i] = mirror ? wdata[7-i] : wdata[i];
            ds   = {dm, 8'h00} >> sh;
            mask = lane_mask(addr, sh);
            d0   = {pix_mem[a1], pix_mem[a2]};
            keep = d0 & ~mask;
            d0   = d0 & mask;
            ds   = ds & mask;
            case (~mode_reg[3:0])
                LF_NOT_S:    res = ds ^ mask;
                LF_NOR:      res = (ds | d0) ^ mask;
                LF_NS_AND_D: res = (ds ^ mask) & d0;
                LF_ZERO:     res = 16'h0000;
                LF_NAND:     res = (ds & d0) ^ mask;
                LF_NOT_D:    res = d0 ^ mask;
                LF_XOR:      res = ds ^ d0;
                LF_S_AND_ND: res = ds & (d0 ^ mask);
                LF_NS_OR_D:  res = (ds ^ mask) | d0;
                LF_XNOR:     res = ds ^ d0 ^ mask;
                LF_DEST:     res = d0;
                LF_AND:      res = ds & d0;
                LF_ONE:      res = mask;
                LF_S_OR_ND:  res = ds | (d0 ^ mask);
                LF_OR:       res = ds | d0;
                default:     res = ds;
            endcase
            res = keep | res;
            pix_mem[a1] = res[15:8];
            pix_mem[a2] = res[7:0];
            // Stamp the latched color into each touched column
            if (!addr[13] && !mode_reg[MODE_COPY_BIT]) begin
                if (mask[15:8] != 8'h00)
                    col_mem[a1] = {3'b000, latch};
                if (mask[7:0] != 8'h00)
                    col_mem[a2] = {3'b000, latch};
            end
        endfunction

        function logic [7:0] stretch_level(input logic [2:0] v);
            return {v, v, v[2:1]};
        endfunction

        function void store_color(input logic [13:0] addr, input logic [7:0] wdata,
                                  inout t_result r);
            logic [12:0] a;
            a = addr[12:0];
            if (a[7:5] == 3'b000) begin
                // Palette region: store in both halves, maybe emit an entry
                col_mem[{a[12:9], 1'b0, a[7:0]}] = wdata;
                col_mem[{a[12:9], 1'b1, a[7:0]}] = wdata;
                latch = wdata[4:0];
                if (mode_reg[MODE_PAL_EN_BIT]) begin
                    r.pal_we    = 1'b1;
                    r.pal_index = {a[9], a[4:0]};
                    r.red       = stretch_level({wdata[1:0], a[8]});
                    r.green     = stretch_level(wdata[7:5]);
                    r.blue      = stretch_level(wdata[4:2]);
                end
            end else begin
                col_mem[a] = mode_reg[MODE_COPY_BIT] ? {3'b000, latch} : {3'b000, wdata[4:0]};
                latch = wdata[4:0];
            end
        endfunction

        // Apply one accepted access and queue the result it should produce
        function void take_access(input logic [1:0] cmd, input logic [13:0] addr,
                                  input logic [7:0] wdata);
            t_result r;
            r = '0;
            case (cmd)
                CMD_VRD: r.read_data = gather_video(addr);
                CMD_VWR: blit_video(addr, wdata);
                CMD_CRD: r.read_data = col_mem[addr[12:0]];
                default: store_color(addr, wdata, r);
            endcase
            expected_q.push_back(r);
        endfunction

        task compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
        endtask

        task match_result(input t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no access outstanding");
            end else begin
                want = expected_q.pop_front();
                compare_field("read_data", got.read_data, want.read_data);
                compare_field("palette_write", {7'd0, got.pal_we}, {7'd0, want.pal_we});
                compare_field("pal_index", {2'd0, got.pal_index}, {2'd0, want.pal_index});
                compare_field("red", got.red, want.red);
                compare_field("green", got.green, want.green);
                compare_field("blue", got.blue, want.blue);
            end
            result_count++;
        endtask

        task flag_leftovers();
            while (expected_q.size() != 0) begin
                void'(expected_q.pop_front());
                report_mismatch("expected result never arrived");
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = 8'h00;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = 24'h000000;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    blit_shadow shadow = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;

    shifting_blitter_video_memory DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    initial begin : result_receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Check every result transfer against the oldest expectation
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got           = '0;
            got.read_data = m_axis_tdata[7:0];
            got.pal_index = m_axis_tdata[13:8];
            got.red       = m_axis_tdata[21:14];
            got.green     = m_axis_tdata[29:22];
            got.blue      = m_axis_tdata[37:30];
            got.pal_we    = m_axis_tuser[0];
            shadow.match_result(got);
        end
    end

    // Called at a falling edge; returns at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one access, with a random gap first; leaves tvalid high on return
    task automatic send_access(input logic [1:0] cmd, input logic [13:0] addr,
                               input logic [7:0] wdata);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= {wdata, addr, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        shadow.take_access(cmd, addr, wdata);
        @(negedge i_clk);
    endtask

    // Drop tvalid and wait until every expected result has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (shadow.expected_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Addresses crowd a few columns and rows so that accesses hit each other
    function automatic logic [13:0] pick_address();
        logic [4:0] col;
        logic [7:0] row;
        int         sel;
        sel = $urandom_range(99);
        if (sel < 30)
            col = 5'h1f;
        else if (sel < 50)
            col = 5'h1e;
        else if (sel < 70)
            col = 5'h00;
        else
            col = 5'($urandom);
        if ($urandom_range(1) == 0)
            row = {3'($urandom_range(7)), 5'($urandom_range(3))};
        else
            row = 8'($urandom);
        return {1'($urandom), col, row};
    endfunction

    task automatic send_random_access();
        logic [1:0] cmd;
        int         sel;
        sel = $urandom_range(99);
        if (sel < 35)
            cmd = CMD_VWR;
        else if (sel < 65)
            cmd = CMD_VRD;
        else if (sel < 80)
            cmd = CMD_CWR;
        else
            cmd = CMD_CRD;
        send_access(cmd, pick_address(), 8'($urandom));
    endtask

    initial begin : stimulus
        logic [7:0] mode_val;
        logic [7:0] shift_val;

        // Reset; registers may be loaded during the clearing pass
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 21;
        recv_idle_pct = 85;

        // Reset settings: pass-through source, protection on
        send_access(CMD_VRD, 14'h0000, 8'h00);
        send_access(CMD_VWR, 14'h0020, 8'hff);
        send_access(CMD_VRD, 14'h0020, 8'h00);
        send_access(CMD_VWR, 14'h0005, 8'haa);
        send_access(CMD_VRD, 14'h0005, 8'h00);
        send_access(CMD_CWR, 14'h0003, 8'hff);
        send_access(CMD_CRD, 14'h0103, 8'h00);
        send_access(CMD_CWR, 14'h00e0, 8'hff);
        send_access(CMD_CRD, 14'h00e0, 8'h00);
        send_access(CMD_VWR, 14'h1f40, 8'h3c);
        send_access(CMD_CRD, 14'h1f40, 8'h00);
        drain_results();

        // All-ones settings: widest shift, mirror, roll, palette, copy-color
        write_reg(REG_SHIFT, 8'hff);
        write_reg(REG_MODE, 8'hff);
        write_reg(REG_SPARE_LO, 8'h00);
        write_reg(REG_SPARE_HI, 8'h5a);
        send_access(CMD_VWR, 14'h3fff, 8'h01);
        send_access(CMD_VRD, 14'h3fff, 8'h00);
        send_access(CMD_VRD, 14'h1fff, 8'h00);
        send_access(CMD_CWR, 14'h3f1f, 8'hff);
        send_access(CMD_CWR, 14'h0000, 8'h00);
        send_access(CMD_CWR, 14'h0040, 8'h13);
        send_access(CMD_CRD, 14'h0040, 8'h00);
        send_access(CMD_VWR, 14'h1234, 8'h5a);
        send_access(CMD_CRD, 14'h1334, 8'h00);
        drain_results();

        // No shift, protect off, inverted destination
        write_reg(REG_SHIFT, 8'h00);
        write_reg(REG_MODE, 8'h2a);
        send_access(CMD_VWR, 14'h0001, 8'h81);
        send_access(CMD_VRD, 14'h0001, 8'h00);
        send_access(CMD_VRD, 14'h2001, 8'h00);
        drain_results();

        // Random phases; each of the first 16 walks a different logic function
        for (int p = 0; p < PHASES; p++) begin
            if (p < 6) begin
                send_idle_pct = 21;
                recv_idle_pct = 85;
            end else if (p < 12) begin
                send_idle_pct = 85;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            shift_val = 8'($urandom);
            mode_val  = {4'($urandom), 4'(p)};
            if (p == PHASES - 2) begin
                shift_val = 8'h00;
                mode_val  = 8'h00;
            end else if (p == PHASES - 1) begin
                shift_val = 8'hff;
                mode_val  = 8'hff;
            end
            write_reg(REG_SHIFT, shift_val);
            write_reg(REG_MODE, mode_val);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Stall the output long enough to back up the input
                if (p == 12 && n == 20)
                    hold_request = 1'b1;
                send_random_access();
            end
            drain_results();
        end

        repeat (20) @(negedge i_clk);
        shadow.flag_leftovers();
        if (shadow.error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/sbvm_pkg.sv
rtl/sbvm_ram.sv
rtl/sbvm_alu.sv
rtl/shifting_blitter_video_memory.sv
dv/testbench.sv
